>>> rtl/lihm_pkg.sv
// Shared types, widths and weight table for the loss-interval history mean block.
`default_nettype none

package lihm_pkg;

	localparam int SEQ_W  = 48;
	localparam int CC_W   = 4;
	localparam int LEN_W  = 32;
	localparam int WGT_W  = 4;
	localparam int WSUM_W = 7;
	localparam int DIVC_W = 4;

	localparam logic [CC_W-1:0] WIN_JUMP = 4'd4;

	localparam logic ACT_UPDATE = 1'b0;
	localparam logic ACT_ADD    = 1'b1;

	typedef struct packed {
		logic load;
		logic rd_cur;
		logic chk_write;
		logic add_write;
		logic add_second;
		logic mean_init;
		logic mean_rd;
		logic mean_acc;
		logic div_init;
		logic div_step;
		logic div_end;
		logic out_load;
	} lihm_cmd_t;

	typedef struct packed {
		logic action;
		logic ctr_zero;
		logic ctr_one;
		logic longer;
		logic add_ok;
		logic mean_last;
		logic div_last;
	} lihm_sts_t;

	function automatic logic [WGT_W-1:0] weight(input logic [2:0] idx);
		logic [WGT_W-1:0] w;
		unique case (idx)
			3'd0, 3'd1, 3'd2, 3'd3: w = 4'd10;
			3'd4:                   w = 4'd8;
			3'd5:                   w = 4'd6;
			3'd6:                   w = 4'd4;
			3'd7:                   w = 4'd2;
			default:                w = 4'd2;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

>>> rtl/lihm_in_if.sv
// Input channel: one history transaction (received packet or loss add).
`default_nettype none

interface lihm_in_if;
	logic                            valid;
	logic                            ready;
	logic                            action;
	logic [lihm_pkg::SEQ_W-1:0]      seqno;
	logic [lihm_pkg::CC_W-1:0]       ccval;
	logic [lihm_pkg::SEQ_W-1:0]      last_rcv_seqno;
	logic [lihm_pkg::LEN_W-1:0]      first_length;

	modport source (
		output valid, action, seqno, ccval, last_rcv_seqno, first_length,
		input  ready
	);
	modport sink (
		input  valid, action, seqno, ccval, last_rcv_seqno, first_length,
		output ready
	);
endinterface

`default_nettype wire

>>> rtl/lihm_out_if.sv
// Output channel: flag and mean interval for each transaction.
`default_nettype none

interface lihm_out_if;
	logic                       valid;
	logic                       ready;
	logic                       flag;
	logic [lihm_pkg::LEN_W-1:0] mean_interval;

	modport source (
		output valid, flag, mean_interval,
		input  ready
	);
	modport sink (
		input  valid, flag, mean_interval,
		output ready
	);
endinterface

`default_nettype wire

>>> rtl/loss_interval_history_mean.sv
// Top level: loss-interval history with weighted mean, controller plus datapath.
//
// Usage:
//   req carries one transaction per handshake: a received packet (action 0)
//   stretches the open interval, a loss (action 1) may open a new interval.
//   rsp returns exactly one transaction for each accepted request: a flag
//   and the weighted mean interval after that request.
//   Requests are taken one at a time; req.ready is high only while idle.
//   When the mean is recomputed, the controller walks the n stored intervals
//   (n up to HISTORY_DEPTH) in the length memory, with one read state and one
//   accumulate state per entry, then a radix-4 divider produces the mean.
//   The result sits in an output register, so a new request is accepted
//   while rsp is stalled; the block only waits when a second result is due.
//   Reset empties the history and clears the mean to zero; no clearing pass.
`default_nettype none

module loss_interval_history_mean #(
	parameter int HISTORY_DEPTH = 9
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	lihm_in_if.sink    req,
	lihm_out_if.source rsp
);

	lihm_pkg::lihm_cmd_t cmd;
	lihm_pkg::lihm_sts_t sts;

	lihm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lihm_dp #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_action (req.action),
		.in_seqno  (req.seqno),
		.in_ccval  (req.ccval),
		.in_last   (req.last_rcv_seqno),
		.in_first  (req.first_length),
		.out_flag  (rsp.flag),
		.out_mean  (rsp.mean_interval)
	);

endmodule

`default_nettype wire

>>> rtl/lihm_ctrl.sv
// Controller state machine sequencing each transaction through the datapath.
`default_nettype none

module lihm_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_ready,
	output logic                     rsp_valid,
	input  wire logic                rsp_ready,
	input  wire lihm_pkg::lihm_sts_t sts,
	output lihm_pkg::lihm_cmd_t      cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RD    = 4'd1;
	localparam logic [3:0] S_CHK   = 4'd2;
	localparam logic [3:0] S_ADDW  = 4'd3;
	localparam logic [3:0] S_ADDW2 = 4'd4;
	localparam logic [3:0] S_MINIT = 4'd5;
	localparam logic [3:0] S_MRD   = 4'd6;
	localparam logic [3:0] S_MACC  = 4'd7;
	localparam logic [3:0] S_DINIT = 4'd8;
	localparam logic [3:0] S_DIV   = 4'd9;
	localparam logic [3:0] S_DEND  = 4'd10;
	localparam logic [3:0] S_OUT   = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = out_valid_q;
	assign out_free  = !out_valid_q || rsp_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_RD;
				end
			end
			S_RD: begin
				cmd.rd_cur = 1'b1;
				if (sts.ctr_zero) begin
					state_d = (sts.action == lihm_pkg::ACT_ADD) ? S_ADDW : S_OUT;
				end else begin
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				if (sts.action == lihm_pkg::ACT_ADD) begin
					state_d = sts.add_ok ? S_ADDW : S_OUT;
				end else if (!sts.longer) begin
					state_d = S_OUT;
				end else begin
					cmd.chk_write = 1'b1;
					state_d       = sts.ctr_one ? S_OUT : S_MINIT;
				end
			end
			S_ADDW: begin
				cmd.add_write = 1'b1;
				state_d       = sts.ctr_zero ? S_OUT : S_ADDW2;
			end
			S_ADDW2: begin
				cmd.add_second = 1'b1;
				state_d        = S_MINIT;
			end
			S_MINIT: begin
				cmd.mean_init = 1'b1;
				state_d       = S_MRD;
			end
			S_MRD: begin
				cmd.mean_rd = 1'b1;
				state_d     = S_MACC;
			end
			S_MACC: begin
				cmd.mean_acc = 1'b1;
				state_d      = sts.mean_last ? S_DINIT : S_MRD;
			end
			S_DINIT: begin
				cmd.div_init = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				state_d      = sts.div_last ? S_DEND : S_DIV;
			end
			S_DEND: begin
				cmd.div_end = 1'b1;
				state_d     = S_OUT;
			end
			S_OUT: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/lihm_dp.sv
// Datapath: interval history memories, sum accumulators, divider and output register.
`default_nettype none

module lihm_dp #(
	parameter int HISTORY_DEPTH = 9
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire lihm_pkg::lihm_cmd_t          cmd,
	output lihm_pkg::lihm_sts_t               sts,
	input  wire logic                         in_action,
	input  wire logic [lihm_pkg::SEQ_W-1:0]   in_seqno,
	input  wire logic [lihm_pkg::CC_W-1:0]    in_ccval,
	input  wire logic [lihm_pkg::SEQ_W-1:0]   in_last,
	input  wire logic [lihm_pkg::LEN_W-1:0]   in_first,
	output logic                              out_flag,
	output logic [lihm_pkg::LEN_W-1:0]        out_mean
);

	localparam int SEQ_W  = lihm_pkg::SEQ_W;
	localparam int CC_W   = lihm_pkg::CC_W;
	localparam int LEN_W  = lihm_pkg::LEN_W;
	localparam int WSUM_W = lihm_pkg::WSUM_W;
	localparam int DIVC_W = lihm_pkg::DIVC_W;
	localparam int SLOT_W = $clog2(HISTORY_DEPTH);
	localparam int CTR_W  = $clog2(2 * HISTORY_DEPTH + 1);
	localparam int LSUM_W = SEQ_W + 2;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);
	localparam logic [CTR_W-1:0]  DEPTH_C   = CTR_W'(HISTORY_DEPTH);
	localparam logic [CTR_W-1:0]  TWO_DEPTH = CTR_W'(2 * HISTORY_DEPTH);
	localparam logic [DIVC_W-1:0] DIV_LAST  = '1;

	function automatic logic [SLOT_W-1:0] slot_of(input logic [CTR_W-1:0] c);
		logic [CTR_W-1:0] m;
		m = c;
		if (m >= DEPTH_C) m = m - DEPTH_C;
		if (m >= DEPTH_C) m = m - DEPTH_C;
		return LAST_SLOT - m[SLOT_W-1:0];
	endfunction

	logic [SEQ_W-1:0]  start_mem  [HISTORY_DEPTH];
	logic [CC_W-1:0]   window_mem [HISTORY_DEPTH];
	logic              closed_mem [HISTORY_DEPTH];
	logic [LEN_W-1:0]  length_mem [HISTORY_DEPTH];

	logic              action_q;
	logic [SEQ_W-1:0]  seq_q;
	logic [CC_W-1:0]   cc_q;
	logic [SEQ_W-1:0]  last_q;
	logic [LEN_W-1:0]  first_q;

	logic [SEQ_W-1:0]  rd_start_q;
	logic [CC_W-1:0]   rd_window_q;
	logic              rd_closed_q;
	logic [LEN_W-1:0]  rd_length_q;

	logic [CTR_W-1:0]  ctr_q;
	logic [LEN_W-1:0]  mean_q;
	logic              flag_q;

	logic [SLOT_W-1:0] idx_q;
	logic [SLOT_W-1:0] ptr_q;
	logic [LEN_W-1:0]  tot0_q;
	logic [LEN_W-1:0]  tot1_q;
	logic [WSUM_W-1:0] wtot_q;
	logic [LEN_W-1:0]  dvd_q;
	logic [WSUM_W:0]   rem_q;
	logic [DIVC_W-1:0] dcnt_q;

	logic [CTR_W-1:0]  ctr_dec;
	logic [CTR_W-1:0]  ctr_inc;
	logic [CTR_W-1:0]  ctr_new;
	logic [SLOT_W-1:0] slot_prev;
	logic [SLOT_W-1:0] slot_next;
	logic [SLOT_W-1:0] rd_addr;
	logic [SLOT_W-1:0] k_idx;

	logic [SEQ_W-1:0]  d48;
	logic [LSUM_W-1:0] len50;
	logic              longer;
	logic              jump;
	logic              delta_pos;
	logic [CC_W-1:0]   wdist;

	logic              len_we;
	logic [SLOT_W-1:0] len_waddr;
	logic [LEN_W-1:0]  len_wdata;
	logic              cl_we;
	logic [SLOT_W-1:0] cl_waddr;
	logic              cl_wdata;

	logic [3:0]                  idx4;
	logic [3:0]                  idx4_prev;
	logic [lihm_pkg::WGT_W-1:0]  w_cur;
	logic [lihm_pkg::WGT_W-1:0]  w_prev;
	logic [LEN_W-1:0]            p0;
	logic [LEN_W-1:0]            p1;
	logic                        use0;

	logic [LEN_W-1:0]  dvd_d;
	logic [WSUM_W:0]   rem_d;

	assign ctr_dec   = (ctr_q == '0) ? '0 : ctr_q - CTR_W'(1);
	assign ctr_inc   = ctr_q + CTR_W'(1);
	assign ctr_new   = (ctr_inc > TWO_DEPTH) ? ctr_inc - DEPTH_C : ctr_inc;
	assign slot_prev = slot_of(ctr_dec);
	assign slot_next = slot_of(ctr_q);
	assign rd_addr   = cmd.mean_rd ? ptr_q : slot_prev;
	assign k_idx     = (ctr_q >= DEPTH_C) ? LAST_SLOT : SLOT_W'(ctr_dec);

	assign d48       = seq_q - rd_start_q;
	assign len50     = {{2{d48[SEQ_W-1]}}, d48} + LSUM_W'(1);
	assign longer    = $signed(len50) > $signed({{(LSUM_W - LEN_W){1'b0}}, rd_length_q});
	assign wdist     = cc_q - rd_window_q;
	assign jump      = wdist > lihm_pkg::WIN_JUMP;
	assign delta_pos = !d48[SEQ_W-1] && (d48 != '0);

	assign sts.action    = action_q;
	assign sts.ctr_zero  = (ctr_q == '0);
	assign sts.ctr_one   = (ctr_q == CTR_W'(1));
	assign sts.longer    = longer;
	assign sts.add_ok    = delta_pos && (rd_closed_q || jump);
	assign sts.mean_last = (idx_q == k_idx);
	assign sts.div_last  = (dcnt_q == DIV_LAST);

	always_comb begin
		len_we    = 1'b0;
		len_waddr = slot_prev;
		len_wdata = len50[LEN_W-1:0];
		cl_we     = 1'b0;
		cl_waddr  = slot_prev;
		cl_wdata  = 1'b1;
		priority if (cmd.chk_write) begin
			len_we = !sts.ctr_one;
			cl_we  = jump;
		end else if (cmd.add_write) begin
			len_we   = 1'b1;
			cl_we    = 1'b1;
			cl_waddr = slot_next;
			cl_wdata = 1'b0;
			if (sts.ctr_zero) begin
				len_waddr = slot_next;
				len_wdata = first_q;
			end else begin
				len_wdata = d48[LEN_W-1:0];
			end
		end else if (cmd.add_second) begin
			len_we    = 1'b1;
			len_wdata = last_q[LEN_W-1:0] - seq_q[LEN_W-1:0] + LEN_W'(1);
		end else begin
			len_we = 1'b0;
			cl_we  = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.add_write) begin
			start_mem[slot_next]  <= seq_q;
			window_mem[slot_next] <= cc_q;
		end
		if (cl_we) begin
			closed_mem[cl_waddr] <= cl_wdata;
		end
		if (len_we) begin
			length_mem[len_waddr] <= len_wdata;
		end
		if (cmd.rd_cur || cmd.mean_rd) begin
			rd_start_q  <= start_mem[rd_addr];
			rd_window_q <= window_mem[rd_addr];
			rd_closed_q <= closed_mem[rd_addr];
			rd_length_q <= length_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= in_action;
			seq_q    <= in_seqno;
			cc_q     <= in_ccval;
			last_q   <= in_last;
			first_q  <= in_first;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q  <= '0;
			mean_q <= '0;
		end else begin
			if (cmd.add_write) begin
				ctr_q <= ctr_new;
				if (sts.ctr_zero) begin
					mean_q <= first_q;
				end
			end
			if (cmd.div_end) begin
				mean_q <= dvd_q;
			end
		end
	end

	assign idx4      = 4'(idx_q);
	assign idx4_prev = idx4 - 4'd1;
	assign w_cur     = lihm_pkg::weight(idx4[2:0]);
	assign w_prev    = lihm_pkg::weight(idx4_prev[2:0]);
	assign use0      = (idx_q != k_idx);
	assign p0        = rd_length_q * LEN_W'(w_cur);
	assign p1        = rd_length_q * LEN_W'(w_prev);

	always_comb begin
		rem_d = rem_q;
		dvd_d = dvd_q;
		for (int j = 0; j < 2; j++) begin
			rem_d = {rem_d[WSUM_W-1:0], dvd_d[LEN_W-1]};
			dvd_d = {dvd_d[LEN_W-2:0], 1'b0};
			if (rem_d >= {1'b0, wtot_q}) begin
				rem_d    = rem_d - {1'b0, wtot_q};
				dvd_d[0] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mean_init) begin
			idx_q  <= '0;
			ptr_q  <= slot_prev;
			tot0_q <= '0;
			tot1_q <= '0;
			wtot_q <= '0;
		end
		if (cmd.mean_acc) begin
			idx_q <= idx_q + SLOT_W'(1);
			ptr_q <= (ptr_q == LAST_SLOT) ? '0 : ptr_q + SLOT_W'(1);
			if (use0) begin
				tot0_q <= tot0_q + p0;
				wtot_q <= wtot_q + WSUM_W'(w_cur);
			end
			if (idx_q != '0) begin
				tot1_q <= tot1_q + p1;
			end
		end
		if (cmd.div_init) begin
			dvd_q  <= (tot0_q > tot1_q) ? tot0_q : tot1_q;
			rem_q  <= '0;
			dcnt_q <= '0;
		end
		if (cmd.div_step) begin
			dvd_q  <= dvd_d;
			rem_q  <= rem_d;
			dcnt_q <= dcnt_q + DIVC_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			flag_q <= 1'b0;
		end
		if (cmd.add_write) begin
			flag_q <= 1'b1;
		end
		if (cmd.div_end && action_q == lihm_pkg::ACT_UPDATE) begin
			flag_q <= (dvd_q < mean_q);
		end
		if (cmd.out_load) begin
			out_flag <= flag_q;
			out_mean <= mean_q;
		end
	end

endmodule

`default_nettype wire

>>> test/testbench.sv
// Testbench for the loss-interval history mean block: directed table plus random transactions.
`default_nettype none

module testbench;

	localparam int SEQ_W = lihm_pkg::SEQ_W;
	localparam int CC_W  = lihm_pkg::CC_W;
	localparam int LEN_W = lihm_pkg::LEN_W;

	localparam int DEPTH = 9;
	localparam int N_RANDOM = 1430;
	localparam logic [SEQ_W-1:0] SEQ_MAX = {SEQ_W{1'b1}};

	typedef struct packed {
		logic             action;
		logic [SEQ_W-1:0] seqno;
		logic [CC_W-1:0]  ccval;
		logic [SEQ_W-1:0] last_rcv;
		logic [LEN_W-1:0] first_len;
	} hist_txn_t;

	typedef struct packed {
		logic             flag;
		logic [LEN_W-1:0] mean;
	} mean_rsp_t;

	typedef struct packed {
		hist_txn_t        txn;
		logic             known;
		logic             flag;
		logic [LEN_W-1:0] mean;
	} table_row_t;

	logic clk;
	logic arst_n;
	lihm_in_if  req_if();
	lihm_out_if rsp_if();

	loss_interval_history_mean #(.HISTORY_DEPTH(DEPTH)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_if.sink),
		.rsp(rsp_if.source)
	);

	logic [SEQ_W-1:0] hist_start [DEPTH];
	logic [CC_W-1:0]  hist_win   [DEPTH];
	logic             hist_closed[DEPTH];
	logic [LEN_W-1:0] hist_len_q [DEPTH];
	int unsigned      entry_ctr;
	logic [LEN_W-1:0] mean_q;

	mean_rsp_t   pending_rsp[$];
	int          error_count;
	logic        send_done;
	logic [SEQ_W-1:0] seq_cursor;
	logic [CC_W-1:0]  cc_cursor;

	function automatic int unsigned slot_of(int unsigned c);
		return DEPTH - 1 - (c % DEPTH);
	endfunction

	function automatic int unsigned filled();
		return entry_ctr < DEPTH ? entry_ctr : DEPTH;
	endfunction

	function automatic longint seq_dist(logic [SEQ_W-1:0] a, logic [SEQ_W-1:0] b);
		logic [SEQ_W-1:0] d;
		d = b - a;
		return longint'({{16{d[SEQ_W-1]}}, d});
	endfunction

	function automatic logic [CC_W-1:0] win_gap(logic [CC_W-1:0] a, logic [CC_W-1:0] b);
		return a - b;
	endfunction

	function automatic logic [3:0] wgt(int unsigned i);
		case (i & 7)
			4: return 4'd8;
			5: return 4'd6;
			6: return 4'd4;
			7: return 4'd2;
			default: return 4'd10;
		endcase
	endfunction

	task automatic recompute_mean();
		int unsigned n;
		int unsigned k;
		logic [LEN_W-1:0] v;
		logic [31:0] s0;
		logic [31:0] s1;
		logic [31:0] wt;
		n = filled();
		s0 = 0;
		s1 = 0;
		wt = 0;
		if (n < 2)
			return;
		k = n - 1;
		for (int unsigned i = 0; i <= k; i++) begin
			v = hist_len_q[slot_of(entry_ctr + 2 * DEPTH - i - 1)];
			if (i < k) begin
				s0 += v * 32'(wgt(i));
				wt += 32'(wgt(i));
			end
			if (i > 0)
				s1 += v * 32'(wgt(i - 1));
		end
		if (wt != 0)
			mean_q = (s0 > s1 ? s0 : s1) / wt;
	endtask

	task automatic predict_history(input hist_txn_t t, output mean_rsp_t r);
		int unsigned cur;
		int unsigned nw;
		longint len;
		logic [LEN_W-1:0] old;
		r.flag = 1'b0;
		old = mean_q;
		cur = slot_of(entry_ctr - 1);
		if (t.action == lihm_pkg::ACT_UPDATE) begin
			if (entry_ctr != 0) begin
				len = seq_dist(hist_start[cur], t.seqno) + 1;
				if (len - longint'({32'd0, hist_len_q[cur]}) > 0) begin
					if (win_gap(t.ccval, hist_win[cur]) > lihm_pkg::WIN_JUMP)
						hist_closed[cur] = 1'b1;
					if (filled() != 1) begin
						hist_len_q[cur] = len[31:0];
						recompute_mean();
						r.flag = mean_q < old;
					end
				end
			end
		end else if (entry_ctr == 0 || (seq_dist(hist_start[cur], t.seqno) > 0 &&
				(hist_closed[cur] ||
				win_gap(t.ccval, hist_win[cur]) > lihm_pkg::WIN_JUMP))) begin
			nw = slot_of(entry_ctr);
			hist_start[nw] = t.seqno;
			hist_win[nw] = t.ccval;
			hist_closed[nw] = 1'b0;
			entry_ctr++;
			r.flag = 1'b1;
			if (entry_ctr == 1) begin
				hist_len_q[nw] = t.first_len;
				mean_q = t.first_len;
			end else begin
				len = seq_dist(hist_start[cur], t.seqno);
				hist_len_q[cur] = len[31:0];
				len = seq_dist(t.seqno, t.last_rcv) + 1;
				hist_len_q[nw] = len[31:0];
				if (entry_ctr > 2 * DEPTH)
					entry_ctr -= DEPTH;
				recompute_mean();
			end
		end
		r.mean = mean_q;
	endtask

	function automatic hist_txn_t make_txn(logic act, logic [SEQ_W-1:0] s, logic [CC_W-1:0] c,
			logic [SEQ_W-1:0] l, logic [LEN_W-1:0] f);
		hist_txn_t t;
		t.action = act;
		t.seqno = s;
		t.ccval = c;
		t.last_rcv = l;
		t.first_len = f;
		return t;
	endfunction

	function automatic logic [47:0] rand48();
		return {16'($urandom()), $urandom()};
	endfunction

	function automatic hist_txn_t random_txn();
		hist_txn_t t;
		int unsigned kind;
		kind = $urandom_range(0, 99);
		t = make_txn(1'($urandom_range(0, 1)), rand48(), 4'($urandom_range(0, 15)),
			rand48(), $urandom());
		if (kind < 85) begin
			if ($urandom_range(0, 4) == 0) begin
				t.action = lihm_pkg::ACT_ADD;
				seq_cursor += SEQ_W'($urandom_range(1, 60));
				if ($urandom_range(0, 1))
					cc_cursor += 4'($urandom_range(5, 8));
				else
					cc_cursor += 4'($urandom_range(0, 4));
				t.last_rcv = seq_cursor + SEQ_W'($urandom_range(0, 40));
				if ($urandom_range(0, 9) == 0)
					t.last_rcv = rand48();
			end else begin
				t.action = lihm_pkg::ACT_UPDATE;
				if ($urandom_range(0, 7) == 0)
					seq_cursor -= SEQ_W'($urandom_range(0, 5));
				else
					seq_cursor += SEQ_W'($urandom_range(1, 30));
				if ($urandom_range(0, 9) == 0)
					cc_cursor += 4'($urandom_range(5, 8));
				else
					cc_cursor += 4'($urandom_range(0, 1));
			end
			t.seqno = seq_cursor;
			t.ccval = cc_cursor;
		end
		return t;
	endfunction

	task automatic send_txn(input hist_txn_t t);
		mean_rsp_t r;
		int unsigned idle;
		idle = $urandom_range(0, 7);
		if (idle != 0) begin
			req_if.valid <= 1'b0;
			repeat (idle) @(negedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.action <= t.action;
		req_if.seqno <= t.seqno;
		req_if.ccval <= t.ccval;
		req_if.last_rcv_seqno <= t.last_rcv;
		req_if.first_length <= t.first_len;
		do @(posedge clk); while (!req_if.ready);
		predict_history(t, r);
		pending_rsp.push_back(r);
		@(negedge clk);
	endtask

	table_row_t direct_rows[] = '{
		'{make_txn(lihm_pkg::ACT_UPDATE, 48'd5, 4'd0, 48'd0, 32'd0), 1'b1, 1'b0, 32'd0},
		'{make_txn(lihm_pkg::ACT_ADD, 48'd100, 4'd0, 48'd120, 32'hFFFF_FFFF),
			1'b1, 1'b1, 32'hFFFF_FFFF},
		'{make_txn(lihm_pkg::ACT_UPDATE, 48'd90, 4'd1, 48'd0, 32'd0),
			1'b1, 1'b0, 32'hFFFF_FFFF},
		'{make_txn(lihm_pkg::ACT_UPDATE, 48'd130, 4'd9, 48'd0, 32'd0),
			1'b1, 1'b0, 32'hFFFF_FFFF},
		'{make_txn(lihm_pkg::ACT_ADD, 48'd140, 4'd9, 48'd150, 32'd7), 1'b0, 1'b0, 32'd0},
		'{make_txn(lihm_pkg::ACT_ADD, 48'd140, 4'd9, 48'd150, 32'd7), 1'b0, 1'b0, 32'd0},
		'{make_txn(lihm_pkg::ACT_UPDATE, 48'd160, 4'd10, 48'd0, 32'd0), 1'b0, 1'b0, 32'd0},
		'{make_txn(lihm_pkg::ACT_UPDATE, 48'd159, 4'd10, 48'd0, 32'd0), 1'b0, 1'b0, 32'd0},
		'{make_txn(lihm_pkg::ACT_ADD, 48'd170, 4'd15, 48'd175, 32'd0), 1'b0, 1'b0, 32'd0},
		'{make_txn(lihm_pkg::ACT_ADD, SEQ_MAX, 4'd15, 48'd3, 32'd0), 1'b0, 1'b0, 32'd0},
		'{make_txn(lihm_pkg::ACT_ADD, 48'd1, 4'd4, SEQ_MAX, 32'd0), 1'b0, 1'b0, 32'd0},
		'{make_txn(lihm_pkg::ACT_UPDATE, 48'h7FFF_FFFF_0000, 4'd9, 48'd0, 32'd0),
			1'b0, 1'b0, 32'd0},
		'{make_txn(lihm_pkg::ACT_ADD, 48'h8000_0000_0010, 4'd15, 48'hFFFF_0000_0000, 32'd0),
			1'b0, 1'b0, 32'd0},
		'{make_txn(lihm_pkg::ACT_ADD, 48'h8000_0000_0100, 4'd5, 48'h8000_0000_0100, 32'd0),
			1'b0, 1'b0, 32'd0},
		'{make_txn(lihm_pkg::ACT_UPDATE, 48'hFFFF_FFFF_FFF0, 4'd0, 48'd0, 32'd0),
			1'b0, 1'b0, 32'd0},
		'{make_txn(lihm_pkg::ACT_UPDATE, 48'h0000_0000_0050, 4'd2, 48'd0, 32'd0),
			1'b0, 1'b0, 32'd0}
	};

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		mean_rsp_t exp_r;
		table_row_t row;
		arst_n = 1'b0;
		error_count = 0;
		send_done = 1'b0;
		entry_ctr = 0;
		mean_q = '0;
		for (int i = 0; i < DEPTH; i++) begin
			hist_start[i] = '0;
			hist_win[i] = '0;
			hist_closed[i] = 1'b0;
			hist_len_q[i] = '0;
		end
		req_if.valid = 1'b0;
		req_if.action = lihm_pkg::ACT_UPDATE;
		req_if.seqno = '0;
		req_if.ccval = '0;
		req_if.last_rcv_seqno = '0;
		req_if.first_length = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		foreach (direct_rows[i]) begin
			row = direct_rows[i];
			send_txn(row.txn);
			if (row.known) begin
				exp_r = pending_rsp[$];
				if (exp_r.flag !== row.flag || exp_r.mean !== row.mean) begin
					$display("%0t: table row %0d expected %b/%h, model %b/%h", $time, i,
						row.flag, row.mean, exp_r.flag, exp_r.mean);
					error_count++;
				end
			end
		end
		seq_cursor = 48'h8000_0000_0100 + 48'd200;
		cc_cursor = 4'd5;
		for (int i = 0; i < N_RANDOM; i++)
			send_txn(random_txn());
		req_if.valid <= 1'b0;
		send_done = 1'b1;
	end

	initial begin
		mean_rsp_t exp_r;
		int unsigned idle;
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			idle = $urandom_range(0, 7);
			if (idle != 0) begin
				rsp_if.ready <= 1'b0;
				repeat (idle) @(negedge clk);
			end
			rsp_if.ready <= 1'b1;
			do @(posedge clk); while (!(rsp_if.valid && rsp_if.ready));
			if (pending_rsp.size() == 0) begin
				$display("%0t: unexpected result flag %b mean %h", $time,
					rsp_if.flag, rsp_if.mean_interval);
				error_count++;
			end else begin
				exp_r = pending_rsp.pop_front();
				if (rsp_if.flag !== exp_r.flag) begin
					$display("%0t: flag expected %b actual %b", $time, exp_r.flag, rsp_if.flag);
					error_count++;
				end
				if (rsp_if.mean_interval !== exp_r.mean) begin
					$display("%0t: mean expected %h actual %h", $time, exp_r.mean,
						rsp_if.mean_interval);
					error_count++;
				end
			end
		end
	end

	initial begin
		wait (send_done);
		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (error_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

	initial begin
		#6000000;
		$display("testbench: done, errors");
		$finish;
	end

endmodule

`default_nettype wire
